FILE: design/gwm_pkg.sv
// Shared types, codes and helpers for the guarded word memory.
package gwm_pkg;

  // Default memory size in bytes.
  localparam int unsigned DEF_MEM_BYTES = 4096;

  // Depth of the work queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Request codes.
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_FULL        = 3'd1;
  localparam logic [2:0] ST_READ_ONLY   = 3'd2;
  localparam logic [2:0] ST_STORE_RANGE = 3'd3;
  localparam logic [2:0] ST_LOAD_RANGE  = 3'd4;

  // Memory operation that the back carries out for a classified item.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] word_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  status;
  } out_item_t;

  // A classified item on its way from the front to the back.
  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  status;
    logic [31:0] address;
    logic [31:0] word_value;
    logic        big_endian;
  } work_t;

  // Position of byte k of a word in the selected byte order, in byte units.
  function automatic logic [1:0] lane_pos(input logic [1:0] k, input logic big);
    lane_pos = big ? (2'd3 - k) : k;
  endfunction

endpackage

FILE: design/gwm_front.sv
// Front part: takes items and the byte-order register, checks bounds, owns the program end.
module gwm_front #(
  parameter int unsigned MEM_BYTES = gwm_pkg::DEF_MEM_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gwm_pkg::in_item_t in_data,
  input  logic             cfg_valid,
  input  logic             cfg_data,
  input  logic             clearing,
  input  logic             q_full,
  output logic             q_push,
  output gwm_pkg::work_t   q_item
);
  import gwm_pkg::*;

  localparam int unsigned PE_W = $clog2(MEM_BYTES + 1);

  logic            big_endian;
  logic [PE_W-1:0] prog_end;
  logic [PE_W-1:0] prog_end_next;
  logic            pe_fits;
  logic            addr_fits;
  logic            below_end;
  logic            accept;

  // Byte-order register.
  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b1;
    end else if (cfg_valid) begin
      big_endian <= cfg_data;
    end
  end

  // Bound checks: a word fits when its last byte lies inside the memory.
  assign pe_fits   = ({{(33 - PE_W){1'b0}}, prog_end} + 33'd4) <= 33'(MEM_BYTES);
  assign addr_fits = ({1'b0, in_data.address} + 33'd4) <= 33'(MEM_BYTES);
  assign below_end = in_data.address < 32'(prog_end);

  assign in_ready = !clearing && !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // Classify the item and work out the next program end.
  always_comb begin
    q_item            = '0;
    q_item.word_value = in_data.word_value;
    q_item.big_endian = big_endian;
    q_item.address    = in_data.address;
    prog_end_next     = prog_end;
    unique case (in_data.req_type)
      REQ_APPEND: begin
        q_item.address = 32'(prog_end);
        if (pe_fits) begin
          q_item.op     = OP_WRITE;
          q_item.status = ST_OK;
          prog_end_next = prog_end + PE_W'(4);
        end else begin
          q_item.op     = OP_NONE;
          q_item.status = ST_FULL;
        end
      end
      REQ_STORE: begin
        if (below_end) begin
          q_item.op     = OP_NONE;
          q_item.status = ST_READ_ONLY;
        end else if (!addr_fits) begin
          q_item.op     = OP_NONE;
          q_item.status = ST_STORE_RANGE;
        end else begin
          q_item.op     = OP_WRITE;
          q_item.status = ST_OK;
        end
      end
      REQ_LOAD: begin
        if (addr_fits) begin
          q_item.op     = OP_READ;
          q_item.status = ST_OK;
        end else begin
          q_item.op     = OP_NONE;
          q_item.status = ST_LOAD_RANGE;
        end
      end
      default: begin
        q_item.op     = OP_NONE;
        q_item.status = ST_OK;
      end
    endcase
  end

  // Program-end pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_end <= '0;
    end else if (accept) begin
      prog_end <= prog_end_next;
    end
  end

endmodule

FILE: design/gwm_queue.sv
// Short work queue between the front and the back.
module gwm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gwm_pkg::work_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output gwm_pkg::work_t head_item
);
  import gwm_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t            slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slot[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/gwm_back.sv
// Back part: four byte banks, the clearing pass and the result register.
module gwm_back #(
  parameter int unsigned MEM_BYTES = gwm_pkg::DEF_MEM_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  output logic              clearing,
  input  logic              q_valid,
  input  gwm_pkg::work_t    q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output gwm_pkg::out_item_t out_data
);
  import gwm_pkg::*;

  localparam int unsigned ROWS  = (MEM_BYTES + 3) / 4;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  logic [1:0]       state;
  logic [ROW_W-1:0] clr_row;
  logic             out_free;
  logic             take;
  logic             out_set;
  logic             bank_we;
  logic [ROW_W-1:0] base_row;
  logic [1:0]       off;
  logic [ROW_W-1:0] bank_row   [4];
  logic [7:0]       bank_wdata [4];
  logic [7:0]       rd_bytes   [4];
  logic [1:0]       off_r;
  logic             big_r;
  logic [31:0]      load_word;

  assign clearing = state == S_CLEAR;
  assign out_free = !out_valid || out_ready;
  assign take     = (state == S_RUN) && q_valid && out_free;
  assign q_pop    = take;
  assign bank_we  = clearing || (take && q_item.op == OP_WRITE);

  // The result register is set when a non-load item is taken, or in the load read state.
  assign out_set  = (take && q_item.op != OP_READ) || (state == S_READ);

  assign off      = q_item.address[1:0];
  assign base_row = q_item.address[ROW_W+1:2];

  // Per-bank row and byte: banks below the offset take the next row.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      if (clearing) begin
        bank_row[b]   = clr_row;
        bank_wdata[b] = 8'h00;
      end else begin
        bank_row[b]   = base_row + ROW_W'(2'(b) < off);
        bank_wdata[b] = q_item.word_value[8 * lane_pos(2'(b) - off, q_item.big_endian) +: 8];
      end
    end
  end

  // Byte banks with a registered read.
  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [7:0] mem [ROWS];
    logic [7:0] rd_q;

    always_ff @(posedge clk) begin
      if (bank_we) begin
        mem[bank_row[gb]] <= bank_wdata[gb];
      end
      rd_q <= mem[bank_row[gb]];
    end

    assign rd_bytes[gb] = rd_q;
  end

  // Put the loaded bytes back into word order.
  always_comb begin
    load_word = '0;
    for (int k = 0; k < 4; k++) begin
      load_word[8 * lane_pos(2'(k), big_r) +: 8] = rd_bytes[2'(k) + off_r];
    end
  end

  // Sequencer: clearing pass, then one item at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= S_RUN;
          end else begin
            clr_row <= clr_row + 1'b1;
          end
        end
        S_RUN: begin
          if (take && q_item.op == OP_READ) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_RUN;
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  // Result payload and the load context.
  always_ff @(posedge clk) begin
    if (take) begin
      off_r              <= off;
      big_r              <= q_item.big_endian;
      out_data.read_data <= '0;
      out_data.status    <= q_item.status;
    end else if (state == S_READ) begin
      out_data.read_data <= load_word;
      out_data.status    <= ST_OK;
    end
  end

endmodule

FILE: design/guarded_word_memory_unit.sv
// Guarded word memory: a byte-addressed store with append, store-word and load-word requests.
//
// After reset the block clears its memory one row of four bytes per cycle and takes no item
// until that is done; the byte-order register may be written meanwhile. The front classifies
// one item per cycle while the queue has room and queues it; the back finishes appends,
// stores and refused requests as it takes them and loads through a read state, since the
// four byte banks have a registered read. Sustained rate is one item per cycle for writes
// while each result is taken at once; the back takes no new item during a load's read
// state. A result waits in the output register while further items are taken into the queue.
module guarded_word_memory_unit #(
  parameter int unsigned MEM_BYTES = gwm_pkg::DEF_MEM_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gwm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gwm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import gwm_pkg::*;

  logic  clearing;
  logic  q_full;
  logic  q_push;
  work_t q_push_item;
  logic  q_pop;
  logic  q_valid;
  work_t q_head;

  // The byte-order register is always writable.
  assign cfg_ready = 1'b1;

  gwm_front #(
    .MEM_BYTES(MEM_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  gwm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_item (q_head)
  );

  gwm_back #(
    .MEM_BYTES(MEM_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_item   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

FILE: design/gwm_checker.sv
// Port-level checks for the guarded word memory, bound to the top level.
module gwm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input gwm_pkg::out_item_t out_data
);
  import gwm_pkg::*;

  // Reset starts the clearing pass, so no item is taken just after it.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("item taken during the clearing pass");

  // No stale result survives a reset.
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  // Only a result with status OK carries data.
  a_data_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.read_data == 32'd0)
    else $error("refused request returned data");

  // Status stays within its defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_LOAD_RANGE)
    else $error("undefined status code");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind guarded_word_memory_unit gwm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

FILE: tb/guarded_word_memory_unit_test.sv
// Self-checking testbench for the guarded word memory unit.
`timescale 1ns / 100ps

module guarded_word_memory_unit_test;
  import gwm_pkg::*;

  localparam int unsigned MEM_BYTES   = DEF_MEM_BYTES;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 70;

  // Request code that the block must treat as a no-op.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_left      = 0;
  logic [31:0] recent_addr    = '0;

  // Mirror of the memory contents, the program end and the byte order, together with the
  // results still owed by the block.
  class word_memory_scoreboard;
    logic [7:0]  mem_bytes [MEM_BYTES];
    int unsigned program_end;
    bit          big_endian;
    out_item_t   expected_q [$];
    int unsigned mismatches;

    function new();
      foreach (mem_bytes[i]) mem_bytes[i] = 8'h00;
      program_end = 0;
      big_endian  = 1'b1;
      mismatches  = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Bit position of the byte at offset k within a word.
    function int unsigned lane_shift(int unsigned k);
      return big_endian ? 24 - 8 * k : 8 * k;
    endfunction

    // True when all four bytes starting at the address lie inside the memory.
    function bit word_fits(logic [31:0] at);
      return ({32'd0, at} + 64'd4) <= 64'(MEM_BYTES);
    endfunction

    function void put_word(logic [31:0] at, logic [31:0] w);
      for (int k = 0; k < 4; k++) mem_bytes[at + k] = w[lane_shift(k) +: 8];
    endfunction

    // Works out the result of an accepted request and updates the mirror.
    function void note_request(in_item_t req);
      out_item_t res;
      res.read_data = '0;
      res.status    = ST_OK;
      case (req.req_type)
        REQ_APPEND: begin
          if (word_fits(program_end)) begin
            put_word(program_end, req.word_value);
            program_end += 4;
          end else begin
            res.status = ST_FULL;
          end
        end
        REQ_STORE: begin
          if (req.address < program_end) res.status = ST_READ_ONLY;
          else if (!word_fits(req.address)) res.status = ST_STORE_RANGE;
          else put_word(req.address, req.word_value);
        end
        REQ_LOAD: begin
          if (word_fits(req.address)) begin
            for (int k = 0; k < 4; k++)
              res.read_data[lane_shift(k) +: 8] = mem_bytes[req.address + k];
          end else begin
            res.status = ST_LOAD_RANGE;
          end
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    // Compares a result from the block with the oldest outstanding one.
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: read_data %h status %0d, nothing outstanding",
                   got.read_data, got.status);
      end else begin
        want = expected_q.pop_front();
        if (got.read_data !== want.read_data || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected read_data %h status %0d, got read_data %h status %0d",
                     want.read_data, want.status, got.read_data, got.status);
        end
      end
    endfunction
  endclass

  word_memory_scoreboard sb;

  guarded_word_memory_unit #(
    .MEM_BYTES(MEM_BYTES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each accepted item, then choose the next ready level. A pending
  // hold-off keeps ready low whatever the stall rate.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t make_req(logic [1:0] kind, logic [31:0] at, logic [31:0] w);
    in_item_t req;
    req.req_type   = kind;
    req.address    = at;
    req.word_value = w;
    return req;
  endfunction

  // Random request, weighted towards appends so that the program area keeps growing, with
  // addresses clustered on the program end, the top of memory and the last word written.
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned pick;
    pick = $urandom_range(99);
    req.req_type = pick < 40 ? REQ_APPEND : pick < 65 ? REQ_STORE :
                   pick < 95 ? REQ_LOAD : REQ_UNUSED;
    case ($urandom_range(9))
      0:       req.address = $urandom;
      1:       req.address = MEM_BYTES - 8 + $urandom_range(15);
      2:       req.address = sb.program_end + $urandom_range(8) - 4;
      3, 4, 5: req.address = recent_addr;
      default: req.address = $urandom_range(MEM_BYTES - 1);
    endcase
    // Half the stores land in the writable region while there is one.
    if (req.req_type == REQ_STORE && sb.program_end + 4 <= MEM_BYTES && $urandom_range(1))
      req.address = $urandom_range(MEM_BYTES - 4, sb.program_end);
    case ($urandom_range(9))
      0:       req.word_value = '0;
      1:       req.word_value = '1;
      default: req.word_value = $urandom;
    endcase
    if (req.req_type == REQ_APPEND) recent_addr = sb.program_end;
    else if (req.req_type == REQ_STORE) recent_addr = req.address;
    return req;
  endfunction

  // Offers one item, holds it until accepted and then perhaps leaves a gap.
  task automatic send_item(input in_item_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stops offering items and waits for every outstanding result.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_byte_order(input logic big);
    cfg_valid <= 1'b1;
    cfg_data  <= big;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.big_endian = big;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed items in the reset byte order: the cleared memory, both ends of the address
    // range, wrap-around addresses, unaligned access, the read-only region and the unused code.
    send_item(make_req(REQ_LOAD, 32'd0, 32'hFFFF_FFFF));
    send_item(make_req(REQ_LOAD, MEM_BYTES - 4, 32'd0));
    send_item(make_req(REQ_LOAD, MEM_BYTES - 3, 32'd0));
    send_item(make_req(REQ_LOAD, 32'hFFFF_FFFF, 32'd0));
    send_item(make_req(REQ_STORE, 32'd0, 32'hFFFF_FFFF));
    send_item(make_req(REQ_LOAD, 32'd0, 32'd0));
    send_item(make_req(REQ_STORE, MEM_BYTES - 4, 32'h1234_5678));
    send_item(make_req(REQ_LOAD, MEM_BYTES - 6, 32'd0));
    send_item(make_req(REQ_STORE, MEM_BYTES - 3, 32'h5555_AAAA));
    send_item(make_req(REQ_STORE, 32'hFFFF_FFFD, 32'hAAAA_5555));
    send_item(make_req(REQ_APPEND, 32'hFFFF_FFFF, 32'hA1B2_C3D4));
    send_item(make_req(REQ_APPEND, 32'd0, 32'h0000_0000));
    send_item(make_req(REQ_STORE, 32'd4, 32'hDEAD_BEEF));
    send_item(make_req(REQ_STORE, 32'd7, 32'hDEAD_BEEF));
    send_item(make_req(REQ_STORE, 32'd8, 32'h8000_0001));
    send_item(make_req(REQ_LOAD, 32'd0, 32'd0));
    send_item(make_req(REQ_LOAD, 32'd2, 32'd0));
    send_item(make_req(REQ_LOAD, 32'd9, 32'd0));
    send_item(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_req(REQ_STORE, 32'hFFFF_FFFF, 32'h0F0F_0F0F));
    send_item(make_req(REQ_LOAD, MEM_BYTES - 4, 32'd0));
    send_item(make_req(REQ_LOAD, 32'hFFFF_FFFC, 32'd0));

    // Random phases, alternating the byte order: free flow, sender gaps, receiver stalls
    // after a long hold-off, and both together with one pause for a full drain.
    for (int phase = 0; phase < 4; phase++) begin
      wait_all_results();
      write_byte_order(phase % 2 == 1);
      send_idle_pct  = (phase == 1) ? 62 : (phase == 3) ? 36 : 0;
      recv_stall_pct = (phase == 2) ? 62 : (phase == 3) ? 36 : 0;
      if (phase == 2) hold_left = 400;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 3 && i == PHASE_ITEMS / 2) wait_all_results();
        send_item(random_request());
      end
    end

    // Fill the program area to the last word, then run on with a full memory.
    wait_all_results();
    write_byte_order(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (sb.program_end + 4 <= MEM_BYTES)
      send_item(make_req(REQ_APPEND, $urandom, $urandom));
    send_item(make_req(REQ_APPEND, 32'd0, 32'h1357_9BDF));
    send_item(make_req(REQ_STORE, MEM_BYTES - 4, 32'h2468_ACE0));
    send_item(make_req(REQ_STORE, MEM_BYTES, 32'h2468_ACE0));
    send_item(make_req(REQ_LOAD, MEM_BYTES - 4, 32'd0));
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    for (int i = 0; i < 40; i++) send_item(random_request());

    // Let the last results arrive and give the block time to show any stray one.
    wait_all_results();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/gwm_pkg.sv
design/gwm_front.sv
design/gwm_queue.sv
design/gwm_back.sv
design/guarded_word_memory_unit.sv
design/gwm_checker.sv
tb/guarded_word_memory_unit_test.sv
